// ===== rtl/pdc_pkg.sv =====
`timescale 1ns / 1ps
package pdc_pkg;

  localparam int PALETTE_DEPTH = 216;
  localparam int PAL_AW        = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RED_FMASK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_FMASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_FMASK  = 2'd3;

  localparam logic [1:0] MODE_PASS32  = 2'd0;
  localparam logic [1:0] MODE_BYTES24 = 2'd1;
  localparam logic [1:0] MODE_WORD16  = 2'd2;
  localparam logic [1:0] MODE_PAL8    = 2'd3;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  localparam logic [1:0]  RST_DEPTH_MODE  = MODE_BYTES24;
  localparam logic [15:0] RST_RED_FMASK   = 16'hF800;
  localparam logic [15:0] RST_GREEN_FMASK = 16'h07E0;
  localparam logic [15:0] RST_BLUE_FMASK  = 16'h001F;

  localparam logic [1:0] BYTE_BEATS_LEFT = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [31:0] pixel_value;
    logic [7:0]  palette_slot;
    logic [7:0]  palette_pixel;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_value;
    logic        last_of_pixel;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] data;
    logic        multi;
  } emit_item_t;

endpackage

// ===== rtl/pdc_quant.sv =====
`timescale 1ns / 1ps
module pdc_quant #(
  parameter int LEVELS = 6
) (
  input  logic [7:0]              red,
  input  logic [7:0]              green,
  input  logic [7:0]              blue,
  output logic [pdc_pkg::PAL_AW-1:0] addr,
  output logic                    in_range
);
  import pdc_pkg::*;

  localparam int LV_W   = $clog2(LEVELS);
  localparam int PROD_W = 8 + $clog2(LEVELS + 1);
  localparam int IDX_W  = $clog2(LEVELS * LEVELS * LEVELS);

  function automatic logic [LV_W-1:0] level(input logic [7:0] c);
    logic [PROD_W-1:0] p;
    logic [LV_W-1:0]   lv;
    p  = PROD_W'(c) * PROD_W'(LEVELS);
    lv = '0;
    for (int k = 1; k < LEVELS; k++) begin
      if (p >= PROD_W'(255 * k)) lv = lv + LV_W'(1);
    end
    return lv;
  endfunction

  logic [IDX_W-1:0] idx;

  assign idx = IDX_W'(level(red)) * IDX_W'(LEVELS * LEVELS)
             + IDX_W'(level(green)) * IDX_W'(LEVELS)
             + IDX_W'(level(blue));

  assign in_range = 32'(idx) < 32'(PALETTE_DEPTH);
  assign addr     = PAL_AW'(idx);

endmodule

// ===== rtl/pdc_palette.sv =====
`timescale 1ns / 1ps
module pdc_palette (
  input  logic                    clk,
  input  logic                    we,
  input  logic [pdc_pkg::PAL_AW-1:0] waddr,
  input  logic [7:0]              wdata,
  input  logic                    re,
  input  logic [pdc_pkg::PAL_AW-1:0] raddr,
  output logic [7:0]              rdata
);
  import pdc_pkg::*;

  logic [7:0] mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pdc_emit.sv =====
`timescale 1ns / 1ps
module pdc_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  pdc_pkg::emit_item_t item,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output pdc_pkg::out_beat_t  out_data
);
  import pdc_pkg::*;

  logic        e_valid;
  logic        e_multi;
  logic [1:0]  e_left;
  logic [31:0] e_data;
  logic        last;
  logic        fire;

  assign last      = (e_left == 2'd0);
  assign fire      = e_valid && out_ready;
  assign free      = !e_valid || (out_ready && last);
  assign out_valid = e_valid;

  assign out_data.out_value     = e_multi ? {24'd0, e_data[7:0]} : e_data;
  assign out_data.last_of_pixel = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
      e_left  <= 2'd0;
    end else if (free) begin
      e_valid <= load;
      e_left  <= item.multi ? BYTE_BEATS_LEFT : 2'd0;
    end else if (fire) begin
      e_left <= e_left - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      e_data  <= item.data;
      e_multi <= item.multi;
    end else if (fire) begin
      e_data <= {8'd0, e_data[31:8]};
    end
  end

endmodule

// ===== rtl/pixel_depth_converter_unit.sv =====
`timescale 1ns / 1ps
// Pixel depth converter. Each convert beat gives one result beat, or three byte beats
// (blue, green, red) in 24-bit mode; palette write beats give none. A new beat is taken
// every cycle while results drain and out_ready holds, giving one pixel per cycle in the
// single-beat modes; in 24-bit mode a pixel waits for the last one's three byte beats,
// set by the single output register. A convert beat is registered with its synchronous
// palette read, then loaded into the output register. Palette holds garbage until written.
module pixel_depth_converter_unit #(
  parameter int CHANNEL_LEVELS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pdc_pkg::in_beat_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pdc_pkg::out_beat_t            out_data
);
  import pdc_pkg::*;

  logic [1:0]  depth_mode;
  logic [15:0] red_fmask;
  logic [15:0] green_fmask;
  logic [15:0] blue_fmask;

  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode  <= RST_DEPTH_MODE;
      red_fmask   <= RST_RED_FMASK;
      green_fmask <= RST_GREEN_FMASK;
      blue_fmask  <= RST_BLUE_FMASK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEPTH_MODE:  depth_mode  <= cfg_data[1:0];
        REG_RED_FMASK:   red_fmask   <= cfg_data;
        REG_GREEN_FMASK: green_fmask <= cfg_data;
        REG_BLUE_FMASK:  blue_fmask  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic              accept;
  logic              conv_acc;
  logic              pal_we;
  logic              pal_re;
  logic [PAL_AW-1:0] q_addr;
  logic              q_in_range;
  logic [7:0]        pal_rdata;

  logic        s1_valid;
  logic [31:0] s1_pix;
  logic        s1_in_range;
  logic        s1_move;
  logic        emit_free;
  emit_item_t  item;
  logic [15:0] word16;

  assign accept   = in_valid && in_ready;
  assign conv_acc = accept && (in_data.opcode == OP_CONVERT);
  assign pal_we   = accept && (in_data.opcode == OP_WRITE)
                 && (in_data.palette_slot < 8'(PALETTE_DEPTH));
  assign pal_re   = conv_acc && q_in_range;

  assign s1_move  = s1_valid && emit_free;
  assign in_ready = !s1_valid || s1_move;

  pdc_quant #(.LEVELS(CHANNEL_LEVELS)) u_quant (
    .red      (in_data.pixel_value[23:16]),
    .green    (in_data.pixel_value[15:8]),
    .blue     (in_data.pixel_value[7:0]),
    .addr     (q_addr),
    .in_range (q_in_range)
  );

  pdc_palette u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_data.palette_slot),
    .wdata (in_data.palette_pixel),
    .re    (pal_re),
    .raddr (q_addr),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= conv_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (conv_acc) begin
      s1_pix      <= in_data.pixel_value;
      s1_in_range <= q_in_range;
    end
  end

  assign word16 = ({11'd0, s1_pix[7:3]} & blue_fmask)
                | ({5'd0, s1_pix[15:8], 3'd0} & green_fmask)
                | ({s1_pix[23:16], 8'd0} & red_fmask);

  always_comb begin
    item.multi = 1'b0;
    case (depth_mode)
      MODE_PASS32:  item.data = s1_pix;
      MODE_BYTES24: begin
        item.data  = {8'd0, s1_pix[23:0]};
        item.multi = 1'b1;
      end
      MODE_WORD16:  item.data = {16'd0, word16};
      MODE_PAL8:    item.data = s1_in_range ? {24'd0, pal_rdata} : 32'd0;
      default:      item.data = s1_pix;
    endcase
  end

  pdc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (s1_move),
    .item      (item),
    .free      (emit_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_bytes_follow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_data.last_of_pixel) |=> out_valid)
    else $error("byte beat sequence broken");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1_pix)))
    else $error("pending pixel lost or changed");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    !(pal_we && pal_re))
    else $error("palette read and write in one cycle");

  a_read_only_on_entry: assert property (@(posedge clk) disable iff (rst)
    pal_re |=> s1_valid)
    else $error("palette read without pending pixel");
`endif

endmodule

// ===== tb/sv/tb_pixel_depth_converter_unit.sv =====
`timescale 1ns / 1ps
module tb_pixel_depth_converter_unit;
  import pdc_pkg::*;

  localparam int unsigned CHANNEL_LEVELS = 6;
  localparam int unsigned CLK_HALF = 2;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_BEATS = 9;

  typedef enum logic [1:0] {ROW_CFG, ROW_BEAT, ROW_FIXED} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    in_beat_t              beat;
    logic [31:0]           fixed_value;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_data;

  logic [1:0]  shadow_mode;
  logic [15:0] shadow_red_fmask;
  logic [15:0] shadow_green_fmask;
  logic [15:0] shadow_blue_fmask;
  logic [7:0]  palette_shadow [PALETTE_DEPTH];
  bit          slot_loaded [PALETTE_DEPTH];

  out_beat_t   expected_beats [$];
  stim_row_t   directed_rows [$];
  out_beat_t   want;
  int unsigned mismatches = 0;
  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  logic [8:0]  stall_tick = '0;

  pixel_depth_converter_unit #(
    .CHANNEL_LEVELS(CHANNEL_LEVELS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always #(CLK_HALF) clk = ~clk;

  function automatic int unsigned channel_level(input logic [7:0] c);
    int unsigned lv;
    lv = (c * CHANNEL_LEVELS) / 255;
    return (lv > CHANNEL_LEVELS - 1) ? CHANNEL_LEVELS - 1 : lv;
  endfunction

  function automatic int unsigned cube_index(input logic [31:0] pix);
    return channel_level(pix[23:16]) * CHANNEL_LEVELS * CHANNEL_LEVELS
         + channel_level(pix[15:8]) * CHANNEL_LEVELS
         + channel_level(pix[7:0]);
  endfunction

  function automatic in_beat_t make_beat(input logic op, input logic [31:0] pix,
                                         input logic [7:0] slot, input logic [7:0] pbyte);
    in_beat_t b;
    b.opcode = op;
    b.pixel_value = pix;
    b.palette_slot = slot;
    b.palette_pixel = pbyte;
    return b;
  endfunction

  function automatic logic [15:0] pick_mask(input logic [15:0] reset_value);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return 16'($urandom_range(0, 65535));
      default: return reset_value;
    endcase
  endfunction

  task automatic push_expect(input logic [31:0] value, input logic last);
    out_beat_t e;
    e.out_value = value;
    e.last_of_pixel = last;
    expected_beats.push_back(e);
  endtask

  task automatic predict_beat(input in_beat_t b);
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] word;
    int unsigned idx;
    red = b.pixel_value[23:16];
    green = b.pixel_value[15:8];
    blue = b.pixel_value[7:0];
    if (b.opcode == OP_WRITE) begin
      if (b.palette_slot < PALETTE_DEPTH) begin
        palette_shadow[b.palette_slot] = b.palette_pixel;
        slot_loaded[b.palette_slot] = 1'b1;
      end
    end else begin
      case (shadow_mode)
        MODE_PASS32: push_expect(b.pixel_value, 1'b1);
        MODE_BYTES24: begin
          push_expect({24'd0, blue}, 1'b0);
          push_expect({24'd0, green}, 1'b0);
          push_expect({24'd0, red}, 1'b1);
        end
        MODE_WORD16: begin
          word = (({8'd0, blue} >> 3) & shadow_blue_fmask)
               | (({8'd0, green} << 3) & shadow_green_fmask)
               | (({8'd0, red} << 8) & shadow_red_fmask);
          push_expect({16'd0, word}, 1'b1);
        end
        default: begin
          idx = cube_index(b.pixel_value);
          push_expect((idx < PALETTE_DEPTH) ? {24'd0, palette_shadow[idx]} : 32'd0, 1'b1);
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] expected_value);
    $display("%0t mismatch %s: got %h, expected %h", $time, what, got, expected_value);
    mismatches++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DEPTH_MODE:  shadow_mode = value[1:0];
      REG_RED_FMASK:   shadow_red_fmask = value;
      REG_GREEN_FMASK: shadow_green_fmask = value;
      REG_BLUE_FMASK:  shadow_blue_fmask = value;
      default: ;
    endcase
  endtask

  task automatic settle_idle();
    in_valid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_beat(input in_beat_t b, input logic use_fixed,
                           input logic [31:0] fixed_value);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (!in_ready);
    if (use_fixed) push_expect(fixed_value, 1'b1);
    else predict_beat(b);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.reg_index = idx;
    r.reg_value = value;
    directed_rows.push_back(r);
  endtask

  task automatic beat_row(input logic op, input logic [31:0] pix,
                          input logic [7:0] slot, input logic [7:0] pbyte);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat = make_beat(op, pix, slot, pbyte);
    directed_rows.push_back(r);
  endtask

  task automatic fixed_row(input logic [31:0] pix, input logic [31:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_FIXED;
    r.beat = make_beat(OP_CONVERT, pix, 8'h00, 8'h00);
    r.fixed_value = value;
    directed_rows.push_back(r);
  endtask

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[8:7])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (stall_tick[2:0] >= 3'd5);
      default: out_ready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with nothing expected", out_data.out_value, '0);
      end else begin
        want = expected_beats.pop_front();
        if (out_data.out_value !== want.out_value)
          report_mismatch("out_value", out_data.out_value, want.out_value);
        if (out_data.last_of_pixel !== want.last_of_pixel)
          report_mismatch("last_of_pixel", 32'(out_data.last_of_pixel),
                          32'(want.last_of_pixel));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_row_t   r;
    in_beat_t    b;
    int unsigned idx;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    shadow_mode = RST_DEPTH_MODE;
    shadow_red_fmask = RST_RED_FMASK;
    shadow_green_fmask = RST_GREEN_FMASK;
    shadow_blue_fmask = RST_BLUE_FMASK;
    foreach (palette_shadow[i]) begin
      palette_shadow[i] = '0;
      slot_loaded[i] = 1'b0;
    end

    beat_row(OP_CONVERT, 32'h12345678, 8'h00, 8'h00);
    beat_row(OP_CONVERT, 32'hFFFFFFFF, 8'hFF, 8'hFF);
    beat_row(OP_CONVERT, 32'h00000000, 8'h00, 8'h00);
    beat_row(OP_WRITE, 32'h00000000, 8'd0, 8'h5A);
    beat_row(OP_WRITE, 32'hFFFFFFFF, 8'd215, 8'hA5);
    beat_row(OP_WRITE, 32'h00000000, 8'd216, 8'hEE);
    beat_row(OP_WRITE, 32'h00000000, 8'd255, 8'h11);
    cfg_row(REG_DEPTH_MODE, {14'd0, MODE_PASS32});
    fixed_row(32'hFFFFFFFF, 32'hFFFFFFFF);
    fixed_row(32'h00000000, 32'h00000000);
    beat_row(OP_CONVERT, 32'hA5C33C5A, 8'hAA, 8'h55);
    cfg_row(REG_DEPTH_MODE, {14'd0, MODE_WORD16});
    fixed_row(32'h00FFFFFF, 32'h0000FFFF);
    fixed_row(32'hFF000000, 32'h00000000);
    beat_row(OP_CONVERT, 32'h00ABCDEF, 8'h00, 8'h00);
    cfg_row(REG_RED_FMASK, 16'hFFFF);
    cfg_row(REG_GREEN_FMASK, 16'hFFFF);
    cfg_row(REG_BLUE_FMASK, 16'hFFFF);
    beat_row(OP_CONVERT, 32'h00ABCDEF, 8'h00, 8'h00);
    cfg_row(REG_RED_FMASK, 16'h0000);
    cfg_row(REG_GREEN_FMASK, 16'h0000);
    cfg_row(REG_BLUE_FMASK, 16'h0000);
    fixed_row(32'hFFFFFFFF, 32'h00000000);
    cfg_row(REG_DEPTH_MODE, {14'd0, MODE_PAL8});
    fixed_row(32'h00FFFFFF, 32'h000000A5);
    fixed_row(32'h00000000, 32'h0000005A);
    beat_row(OP_WRITE, 32'h00000000, 8'd100, 8'h3C);
    beat_row(OP_CONVERT, 32'h0060C0C0, 8'h00, 8'h00);
    beat_row(OP_CONVERT, 32'hFF000000, 8'h00, 8'h00);
    beat_row(OP_CONVERT, 32'h00FEFEFE, 8'h00, 8'h00);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      case (r.kind)
        ROW_CFG: begin
          settle_idle();
          write_reg(r.reg_index, r.reg_value);
        end
        ROW_BEAT: send_beat(r.beat, 1'b0, '0);
        default: send_beat(r.beat, 1'b1, r.fixed_value);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      write_reg(REG_DEPTH_MODE, CFG_DATA_W'(p % 4));
      write_reg(REG_RED_FMASK, pick_mask(RST_RED_FMASK));
      write_reg(REG_GREEN_FMASK, pick_mask(RST_GREEN_FMASK));
      write_reg(REG_BLUE_FMASK, pick_mask(RST_BLUE_FMASK));
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 3 && k == PHASE_BEATS / 2) settle_idle();
        if ($urandom_range(0, 3) == 0) begin
          b = make_beat(OP_WRITE, $urandom,
                        ($urandom_range(0, 7) == 0) ? 8'($urandom_range(216, 255))
                                                    : 8'($urandom_range(0, 215)),
                        8'($urandom));
        end else begin
          b = make_beat(OP_CONVERT, $urandom, 8'($urandom), 8'($urandom));
          idx = cube_index(b.pixel_value);
          if (shadow_mode == MODE_PAL8 && idx < PALETTE_DEPTH && !slot_loaded[idx])
            send_beat(make_beat(OP_WRITE, $urandom, 8'(idx), 8'($urandom)), 1'b0, '0);
        end
        send_beat(b, 1'b0, '0);
      end
    end

    settle_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
